>>> hdl/ole_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_pkg
// Shared sizes, operation and status codes for the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;
  localparam int LIST_DEPTH = 64;
  localparam int DATA_WIDTH = 32;

  localparam logic [3:0] OP_APPEND   = 4'd0;
  localparam logic [3:0] OP_PREPEND  = 4'd1;
  localparam logic [3:0] OP_INS_AT   = 4'd2;
  localparam logic [3:0] OP_INS_KEY  = 4'd3;
  localparam logic [3:0] OP_DEL_AT   = 4'd4;
  localparam logic [3:0] OP_DEL_RNG  = 4'd5;
  localparam logic [3:0] OP_DEL_FST  = 4'd6;
  localparam logic [3:0] OP_DEL_ALL  = 4'd7;
  localparam logic [3:0] OP_GET      = 4'd8;
  localparam logic [3:0] OP_FIND     = 4'd9;
  localparam logic [3:0] OP_CLEAR    = 4'd10;
  localparam logic [3:0] OP_DUMP     = 4'd11;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NF    = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;
endpackage

>>> hdl/ordered_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of signed values held contiguously in one RAM.
// ----------------------------------------------------------------------------
// Usage: drive the operation fields and hold start high; the transaction is
// taken at the first rising edge with busy low, and busy stays high from
// then until the final result has been presented.
// Results appear one per cycle on the result ports, marked by strobe; only
// dump gives more than one, and the final result of a transaction carries
// last. The receiver cannot stall, so each result is presented for one cycle.
// Sequencing: one shared compare/copy path walks the RAM through its single
// registered read port; each element searched or shifted is read, then
// compared or written, while inserted copies and dumped elements follow one
// another. Checks that touch no element go from decode straight to the
// result. One transaction at a time.
// Reset: rst clears the element count and the sequencer; RAM contents are
// left as they are, as only positions below the count are ever read.
// ----------------------------------------------------------------------------
module ordered_list_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [3:0]                    operation,
  input  logic [6:0]                    index,
  input  logic [6:0]                    end_index,
  input  logic signed [31:0]            value,
  input  logic signed [31:0]            key,
  input  logic [6:0]                    repeat_count,
  output logic                          strobe,
  output logic [1:0]                    status,
  output logic signed [31:0]            data_out,
  output logic [5:0]                    position,
  output logic [6:0]                    list_count,
  output logic                          last
);
  localparam int DEPTH      = ole_pkg::LIST_DEPTH;
  localparam int DATA_WIDTH = ole_pkg::DATA_WIDTH;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW:0] DEPTH_C = (CW+1)'(DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;  // search: issue read
  localparam logic [3:0] S_SCMP  = 4'd3;  // search: compare
  localparam logic [3:0] S_ORD   = 4'd4;  // open gap: read
  localparam logic [3:0] S_OWR   = 4'd5;  // open gap: write
  localparam logic [3:0] S_FILL  = 4'd6;
  localparam logic [3:0] S_CRD   = 4'd7;  // close gap / compact: read
  localparam logic [3:0] S_CWR   = 4'd8;
  localparam logic [3:0] S_GRD   = 4'd9;
  localparam logic [3:0] S_GOUT  = 4'd10;
  localparam logic [3:0] S_DRD   = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0]            state;
  logic [3:0]            op;
  logic [6:0]            idx, endi, rep;
  logic [DATA_WIDTH-1:0] val, kval;
  logic [CW-1:0]         count;
  logic [CW:0]           rd, wr;   // read and write pointers
  logic [CW:0]           gap;      // shift distance
  logic [CW:0]           lim;      // loop bound
  logic [1:0]            st;

  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;
  logic                  match;

  ole_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign busy = (state != S_IDLE);

  // read address follows the pointer so data arrives in the next state
  always_comb begin
    if (state == S_ORD) raddr = AW'(rd - 1'b1);
    else                raddr = AW'(rd);
  end

  // single compare unit, shared by all searches
  always_comb begin
    if (op == ole_pkg::OP_INS_KEY) match = (rdata == kval);
    else                           match = (rdata == val);
  end

  logic [CW:0] cnt_x;
  assign cnt_x = (CW+1)'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      strobe <= 1'b0;
      we     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      we     <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op    <= operation;
            idx   <= index;
            endi  <= end_index;
            val   <= DATA_WIDTH'(value);
            kval  <= DATA_WIDTH'(key);
            rep   <= repeat_count;
            st    <= ole_pkg::ST_OK;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          state <= S_DONE;
          priority case (op)
            ole_pkg::OP_APPEND, ole_pkg::OP_PREPEND: begin
              if (cnt_x >= DEPTH_C) st <= ole_pkg::ST_FULL;
              else begin
                gap   <= (CW+1)'(1);
                lim   <= (op == ole_pkg::OP_APPEND) ? cnt_x : '0;
                rd    <= cnt_x;
                state <= S_ORD;
              end
            end
            ole_pkg::OP_INS_AT: begin
              if ((CW+1)'(idx) > cnt_x) st <= ole_pkg::ST_RANGE;
              else if (rep == 7'd0) st <= ole_pkg::ST_OK;
              else if (cnt_x + (CW+1)'(rep) > DEPTH_C) st <= ole_pkg::ST_FULL;
              else begin
                gap   <= (CW+1)'(rep);
                lim   <= (CW+1)'(idx);
                rd    <= cnt_x;
                state <= S_ORD;
              end
            end
            ole_pkg::OP_INS_KEY, ole_pkg::OP_DEL_FST, ole_pkg::OP_FIND: begin
              rd    <= '0;
              state <= S_SRD;
            end
            ole_pkg::OP_DEL_AT: begin
              if ((CW+1)'(idx) >= cnt_x) st <= ole_pkg::ST_RANGE;
              else begin
                wr <= (CW+1)'(idx); rd <= (CW+1)'(idx) + 1'b1; state <= S_CRD;
              end
            end
            ole_pkg::OP_DEL_RNG: begin
              if ((CW+1)'(idx) >= cnt_x || endi < idx) st <= ole_pkg::ST_RANGE;
              else begin
                wr <= (CW+1)'(idx);
                rd <= ((CW+1)'(endi) >= cnt_x) ? cnt_x : (CW+1)'(endi) + 1'b1;
                state <= S_CRD;
              end
            end
            ole_pkg::OP_DEL_ALL: begin
              wr <= '0; rd <= '0; state <= S_CRD;
            end
            ole_pkg::OP_GET: begin
              if ((CW+1)'(idx) >= cnt_x) st <= ole_pkg::ST_RANGE;
              else begin
                rd <= (CW+1)'(idx); state <= S_GRD;
              end
            end
            ole_pkg::OP_CLEAR: count <= '0;
            ole_pkg::OP_DUMP: begin
              if (count == '0) st <= ole_pkg::ST_NF;
              else begin
                rd <= '0; state <= S_DRD;
              end
            end
            default: st <= ole_pkg::ST_OK;
          endcase
        end
        S_SRD: begin
          if (rd >= cnt_x) begin
            st    <= ole_pkg::ST_NF;
            state <= S_DONE;
          end else begin
            state <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (match) begin
            priority case (op)
              ole_pkg::OP_INS_KEY: begin
                if (cnt_x >= DEPTH_C) begin
                  st <= ole_pkg::ST_FULL; state <= S_DONE;
                end else begin
                  gap <= (CW+1)'(1); lim <= rd; rd <= cnt_x; state <= S_ORD;
                end
              end
              ole_pkg::OP_DEL_FST: begin
                wr <= rd; rd <= rd + 1'b1; state <= S_CRD;
              end
              default: begin
                strobe     <= 1'b1;
                status     <= ole_pkg::ST_OK;
                data_out   <= '0;
                position   <= 6'(rd);
                list_count <= 7'(count);
                last       <= 1'b1;
                state      <= S_IDLE;
              end
            endcase
          end else begin
            rd    <= rd + 1'b1;
            state <= S_SRD;
          end
        end
        S_ORD: begin
          if (rd > lim) begin
            state <= S_OWR;
          end else begin
            wr    <= lim;
            state <= S_FILL;
          end
        end
        S_OWR: begin
          we    <= 1'b1;
          waddr <= AW'(rd - 1'b1 + gap);
          wdata <= rdata;
          rd    <= rd - 1'b1;
          state <= S_ORD;
        end
        S_FILL: begin
          if (gap == '0) begin
            state <= S_DONE;
          end else begin
            we    <= 1'b1;
            waddr <= AW'(wr);
            wdata <= val;
            wr    <= wr + 1'b1;
            gap   <= gap - 1'b1;
            count <= count + 1'b1;
          end
        end
        S_CRD: begin
          if (rd >= cnt_x) begin
            if (op == ole_pkg::OP_DEL_ALL && wr == cnt_x) st <= ole_pkg::ST_NF;
            count <= CW'(wr);
            state <= S_DONE;
          end else begin
            state <= S_CWR;
          end
        end
        S_CWR: begin
          if (op != ole_pkg::OP_DEL_ALL || rdata != val) begin
            we    <= 1'b1;
            waddr <= AW'(wr);
            wdata <= rdata;
            wr    <= wr + 1'b1;
          end
          rd    <= rd + 1'b1;
          state <= S_CRD;
        end
        S_GRD: begin
          state <= S_GOUT;
        end
        S_GOUT: begin
          strobe     <= 1'b1;
          status     <= ole_pkg::ST_OK;
          data_out   <= 32'(signed'(rdata));
          position   <= '0;
          list_count <= 7'(count);
          last       <= 1'b1;
          state      <= S_IDLE;
        end
        S_DRD: begin
          // read pipeline: rd addresses the RAM, and the registered read data is emitted with position rd-1
          if (rd < cnt_x) begin
            rd    <= rd + 1'b1;
          end
          if (rd != '0) begin
            strobe     <= 1'b1;
            status     <= ole_pkg::ST_OK;
            data_out   <= 32'(signed'(rdata));
            position   <= 6'(rd - 1'b1);
            list_count <= 7'(count);
            last       <= (rd == cnt_x);
            if (rd == cnt_x) state <= S_IDLE;
          end
        end
        S_DONE: begin
          strobe     <= 1'b1;
          status     <= st;
          data_out   <= '0;
          position   <= '0;
          list_count <= 7'(count);
          last       <= 1'b1;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (CW+1)'(count) <= DEPTH_C) else $error("count exceeds depth");
  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> state == S_IDLE) else $error("final result while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("transaction not taken");
`endif
endmodule

>>> hdl/ole_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered list engine: a directed table of list
// operations, a full-list stretch and random sequences, every result compared
// against a behavioural list model kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  localparam int LIST_DEPTH = 64;
  localparam int RAND_ITEMS = 440;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_out;
    logic [5:0]  position;
    logic [6:0]  list_count;
    logic        last;
  } list_result_t;

  typedef struct {
    logic [3:0]  operation;
    logic [6:0]  index;
    logic [6:0]  end_index;
    logic [31:0] value;
    logic [31:0] key;
    logic [6:0]  repeat_count;
    bit          typed;
    logic [1:0]  exp_status;
  } list_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [3:0] operation = '0;
  logic [6:0] index = '0;
  logic [6:0] end_index = '0;
  logic signed [31:0] value = '0;
  logic signed [31:0] key = '0;
  logic [6:0] repeat_count = '0;
  logic strobe;
  logic [1:0] status;
  logic signed [31:0] data_out;
  logic [5:0] position;
  logic [6:0] list_count;
  logic last;

  logic [31:0] shadow_list[LIST_DEPTH];
  int unsigned shadow_count = 0;
  list_result_t pending_results[$];
  int error_count = 0;
  int result_count = 0;
  int items_sent = 0;
  longint cycle_count = 0;
  list_cmd_t directed_table[$];

  always #4 clk = ~clk;

  ordered_list_engine DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .index(index), .end_index(end_index),
    .value(value), .key(key), .repeat_count(repeat_count),
    .strobe(strobe), .status(status), .data_out(data_out),
    .position(position), .list_count(list_count), .last(last)
  );

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    $display("MISMATCH t=%0t %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  function automatic int find_first(input logic [31:0] v);
    for (int i = 0; i < shadow_count; i++)
      if (shadow_list[i] == v) return i;
    return -1;
  endfunction

  function automatic void open_gap(input int at, input int n);
    for (int i = shadow_count; i > at; i--) shadow_list[i - 1 + n] = shadow_list[i - 1];
  endfunction

  function automatic void close_gap(input int at, input int n);
    for (int i = at; i + n < shadow_count; i++) shadow_list[i] = shadow_list[i + n];
    shadow_count -= n;
  endfunction

  // Applies one transaction to the bench's list and queues the results it owes
  function automatic void predict_list_op(input list_cmd_t c);
    list_result_t r;
    logic [1:0] st;
    int p, w, count_before, e;
    st = ole_pkg::ST_OK;
    r = '0;
    case (c.operation)
      ole_pkg::OP_APPEND, ole_pkg::OP_PREPEND: begin
        if (shadow_count >= LIST_DEPTH) st = ole_pkg::ST_FULL;
        else begin
          p = (c.operation == ole_pkg::OP_APPEND) ? shadow_count : 0;
          open_gap(p, 1);
          shadow_list[p] = c.value;
          shadow_count++;
        end
      end
      ole_pkg::OP_INS_AT: begin
        if (c.index > shadow_count) st = ole_pkg::ST_RANGE;
        else if (c.repeat_count != 0) begin
          if (shadow_count + c.repeat_count > LIST_DEPTH) st = ole_pkg::ST_FULL;
          else begin
            open_gap(int'(c.index), int'(c.repeat_count));
            for (int i = 0; i < c.repeat_count; i++) shadow_list[c.index + i] = c.value;
            shadow_count += c.repeat_count;
          end
        end
      end
      ole_pkg::OP_INS_KEY: begin
        p = find_first(c.key);
        if (p < 0) st = ole_pkg::ST_NF;
        else if (shadow_count >= LIST_DEPTH) st = ole_pkg::ST_FULL;
        else begin
          open_gap(p, 1);
          shadow_list[p] = c.value;
          shadow_count++;
        end
      end
      ole_pkg::OP_DEL_AT: begin
        if (c.index >= shadow_count) st = ole_pkg::ST_RANGE;
        else close_gap(int'(c.index), 1);
      end
      ole_pkg::OP_DEL_RNG: begin
        if (c.index >= shadow_count || c.end_index < c.index) st = ole_pkg::ST_RANGE;
        else begin
          e = (c.end_index >= shadow_count) ? shadow_count - 1 : int'(c.end_index);
          close_gap(int'(c.index), e - int'(c.index) + 1);
        end
      end
      ole_pkg::OP_DEL_FST: begin
        p = find_first(c.value);
        if (p < 0) st = ole_pkg::ST_NF;
        else close_gap(p, 1);
      end
      ole_pkg::OP_DEL_ALL: begin
        w = 0;
        count_before = shadow_count;
        for (int i = 0; i < count_before; i++)
          if (shadow_list[i] != c.value) shadow_list[w++] = shadow_list[i];
        shadow_count = w;
        if (w == count_before) st = ole_pkg::ST_NF;
      end
      ole_pkg::OP_GET: begin
        if (c.index >= shadow_count) st = ole_pkg::ST_RANGE;
        else r.data_out = shadow_list[c.index];
      end
      ole_pkg::OP_FIND: begin
        p = find_first(c.value);
        if (p < 0) st = ole_pkg::ST_NF;
        else r.position = 6'(p);
      end
      ole_pkg::OP_CLEAR: shadow_count = 0;
      ole_pkg::OP_DUMP: begin
        if (shadow_count == 0) st = ole_pkg::ST_NF;
        else begin
          for (int i = 0; i < shadow_count; i++) begin
            r = '0;
            r.data_out = shadow_list[i];
            r.position = 6'(i);
            r.list_count = 7'(shadow_count);
            r.last = (i == shadow_count - 1);
            pending_results.push_back(r);
          end
          return;
        end
      end
      default: ;
    endcase
    r.status = st;
    r.list_count = 7'(shadow_count);
    r.last = 1'b1;
    pending_results.push_back(r);
  endfunction

  function automatic list_cmd_t make_cmd(input logic [3:0] op, input int idx, input int endi,
                                         input logic [31:0] v, input logic [31:0] k,
                                         input int rep);
    list_cmd_t c;
    c.operation = op; c.index = 7'(idx); c.end_index = 7'(endi);
    c.value = v; c.key = k; c.repeat_count = 7'(rep);
    c.typed = 1'b0; c.exp_status = ole_pkg::ST_OK;
    return c;
  endfunction

  function automatic list_cmd_t typed_cmd(input list_cmd_t c, input logic [1:0] st);
    c.typed = 1'b1;
    c.exp_status = st;
    return c;
  endfunction

  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return;
    repeat (r < 92 ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(posedge clk);
  endtask

  // holds start until an edge with busy low takes the transaction
  task automatic send_cmd(input list_cmd_t c);
    list_result_t expected_head;
    int head_pos;
    start <= 1'b1;
    operation <= c.operation; index <= c.index; end_index <= c.end_index;
    value <= c.value; key <= c.key; repeat_count <= c.repeat_count;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    head_pos = pending_results.size();
    predict_list_op(c);
    // hand-typed status checked against the model's predicted head result of the transaction
    if (c.typed) begin
      expected_head = pending_results[head_pos];
      if (expected_head.status != c.exp_status)
        report_mismatch("directed status", expected_head.status, c.exp_status);
    end
    items_sent++;
    @(posedge clk);
  endtask

  // a value picked from the current list most of the time, to hit matches
  function automatic logic [31:0] pick_value();
    if (shadow_count != 0 && $urandom_range(0, 99) < 60)
      return shadow_list[$urandom_range(0, shadow_count - 1)];
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: return 32'h8000_0000 | $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic list_cmd_t random_cmd();
    int w;
    logic [3:0] op;
    int hi;
    w = $urandom_range(0, 99);
    if (w < 20) op = ole_pkg::OP_APPEND;
    else if (w < 28) op = ole_pkg::OP_PREPEND;
    else if (w < 36) op = ole_pkg::OP_INS_AT;
    else if (w < 44) op = ole_pkg::OP_INS_KEY;
    else if (w < 51) op = ole_pkg::OP_DEL_AT;
    else if (w < 56) op = ole_pkg::OP_DEL_RNG;
    else if (w < 62) op = ole_pkg::OP_DEL_FST;
    else if (w < 66) op = ole_pkg::OP_DEL_ALL;
    else if (w < 76) op = ole_pkg::OP_GET;
    else if (w < 84) op = ole_pkg::OP_FIND;
    else if (w < 86) op = ole_pkg::OP_CLEAR;
    else if (w < 95) op = ole_pkg::OP_DUMP;
    else op = 4'($urandom_range(0, 15));
    hi = shadow_count + 1;
    return make_cmd(op,
      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, hi),
      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, hi),
      pick_value(), pick_value(),
      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 4));
  endfunction

  always @(posedge clk) begin
    list_result_t got, want;
    cycle_count <= cycle_count + 1;
    if (!rst && strobe) begin
      got = '{status, data_out, position, list_count, last};
      result_count++;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("MISMATCH t=%0t unexpected result transaction", $time);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.data_out !== want.data_out) report_mismatch("data_out", got.data_out, want.data_out);
        if (got.position !== want.position) report_mismatch("position", got.position, want.position);
        if (got.list_count !== want.list_count)
          report_mismatch("list_count", got.list_count, want.list_count);
        if (got.last !== want.last) report_mismatch("last", got.last, want.last);
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int waited;
    // empty list corners, extremes, full list, range errors, unused code
    directed_table.push_back(typed_cmd(make_cmd(ole_pkg::OP_DUMP, 0, 0, 0, 0, 0),
                                       ole_pkg::ST_NF));
    directed_table.push_back(typed_cmd(make_cmd(ole_pkg::OP_GET, 0, 0, 0, 0, 0),
                                       ole_pkg::ST_RANGE));
    directed_table.push_back(typed_cmd(make_cmd(ole_pkg::OP_INS_KEY, 0, 0, 5, 5, 0),
                                       ole_pkg::ST_NF));
    directed_table.push_back(typed_cmd(make_cmd(ole_pkg::OP_DEL_ALL, 0, 0, 5, 0, 0),
                                       ole_pkg::ST_NF));
    directed_table.push_back(typed_cmd(make_cmd(ole_pkg::OP_APPEND, 0, 0, 32'h7fff_ffff, 0, 0),
                                       ole_pkg::ST_OK));
    directed_table.push_back(typed_cmd(make_cmd(ole_pkg::OP_PREPEND, 127, 127, 32'h8000_0000,
                                                32'hffff_ffff, 127), ole_pkg::ST_OK));
    directed_table.push_back(typed_cmd(make_cmd(ole_pkg::OP_INS_AT, 3, 0, 1, 0, 1),
                                       ole_pkg::ST_RANGE));
    directed_table.push_back(typed_cmd(make_cmd(ole_pkg::OP_INS_AT, 1, 0, 1, 0, 0),
                                       ole_pkg::ST_OK));
    directed_table.push_back(typed_cmd(make_cmd(ole_pkg::OP_INS_AT, 2, 0, 9, 0, 3),
                                       ole_pkg::ST_OK));
    directed_table.push_back(make_cmd(ole_pkg::OP_INS_KEY, 0, 0, 4, 9, 0));
    directed_table.push_back(make_cmd(ole_pkg::OP_FIND, 0, 0, 9, 0, 0));
    directed_table.push_back(make_cmd(ole_pkg::OP_GET, 0, 0, 0, 0, 0));
    directed_table.push_back(make_cmd(ole_pkg::OP_DUMP, 0, 0, 0, 0, 0));
    directed_table.push_back(typed_cmd(make_cmd(ole_pkg::OP_DEL_RNG, 2, 1, 0, 0, 0),
                                       ole_pkg::ST_RANGE));
    directed_table.push_back(typed_cmd(make_cmd(ole_pkg::OP_DEL_RNG, 64, 64, 0, 0, 0),
                                       ole_pkg::ST_RANGE));
    directed_table.push_back(make_cmd(ole_pkg::OP_DEL_RNG, 1, 2, 0, 0, 0));
    directed_table.push_back(make_cmd(ole_pkg::OP_DEL_FST, 0, 0, 9, 0, 0));
    directed_table.push_back(make_cmd(ole_pkg::OP_DEL_ALL, 0, 0, 9, 0, 0));
    directed_table.push_back(typed_cmd(make_cmd(ole_pkg::OP_DEL_AT, 64, 0, 0, 0, 0),
                                       ole_pkg::ST_RANGE));
    directed_table.push_back(make_cmd(ole_pkg::OP_DEL_AT, 0, 0, 0, 0, 0));
    directed_table.push_back(typed_cmd(make_cmd(4'd15, 0, 0, 0, 0, 0), ole_pkg::ST_OK));
    directed_table.push_back(make_cmd(ole_pkg::OP_INS_AT, 0, 0, 32'h5555_aaaa, 0, 64));
    directed_table.push_back(make_cmd(ole_pkg::OP_INS_AT, 0, 0, 7, 0, 63));
    directed_table.push_back(make_cmd(ole_pkg::OP_APPEND, 0, 0, 1, 0, 0));
    directed_table.push_back(typed_cmd(make_cmd(ole_pkg::OP_CLEAR, 0, 0, 0, 0, 0),
                                       ole_pkg::ST_OK));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_table[i]) begin
      send_cmd(directed_table[i]);
      idle_gap();
    end
    // full-list stretch: fill to capacity, then hit every full refusal
    send_cmd(make_cmd(ole_pkg::OP_INS_AT, 0, 0, 3, 0, 63));
    send_cmd(make_cmd(ole_pkg::OP_APPEND, 0, 0, 4, 0, 0));
    send_cmd(typed_cmd(make_cmd(ole_pkg::OP_APPEND, 0, 0, 5, 0, 0), ole_pkg::ST_FULL));
    send_cmd(typed_cmd(make_cmd(ole_pkg::OP_PREPEND, 0, 0, 5, 0, 0), ole_pkg::ST_FULL));
    send_cmd(typed_cmd(make_cmd(ole_pkg::OP_INS_KEY, 0, 0, 5, 4, 0), ole_pkg::ST_FULL));
    send_cmd(typed_cmd(make_cmd(ole_pkg::OP_INS_AT, 64, 0, 5, 0, 1), ole_pkg::ST_FULL));
    send_cmd(make_cmd(ole_pkg::OP_DUMP, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ole_pkg::OP_DEL_RNG, 0, 127, 0, 0, 0));

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // bursts of appends keep the list deep enough for shifts and searches
      if (shadow_count < 8 && $urandom_range(0, 3) != 0)
        send_cmd(make_cmd(ole_pkg::OP_APPEND, 0, 0, pick_value(), 0, 0));
      else
        send_cmd(random_cmd());
      if ($urandom_range(0, 4) != 0) idle_gap();
    end

    waited = 0;
    while (pending_results.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);

    $display("covered %0d transactions, %0d result transactions checked",
             items_sent, result_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d errors, %0d results outstanding", error_count, pending_results.size());
      $display("simulation failed");
    end
    $finish;
  end
endmodule
